// ===== hdl/ibwt_pkg.sv =====
// Shared types and constants of the inverse BWT block.
// Depends on nothing; every other file but ibwt_ram refers to it by scoped names.
package ibwt_pkg;

  localparam int BlockMax = 65536;
  localparam int AddrW    = $clog2(BlockMax);
  localparam int LenW     = AddrW + 1;
  localparam int CntW     = AddrW + 1;
  localparam int SymN     = 256;

  typedef enum logic [1:0] {
    ST_DATA   = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_REJECT = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_DRAIN = 1'b1
  } req_e;

  // One request as it travels from the front to the back.
  typedef struct packed {
    req_e        req;
    logic [7:0]  data;
    logic        last;
    logic [15:0] origin;
  } item_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LD_WR,
    BK_PFX_RD,
    BK_PFX_WR,
    BK_WK_RD,
    BK_WK_CNT,
    BK_WK_NXT,
    BK_RES,
    BK_DRN_OUT
  } back_state_e;

endpackage

// ===== hdl/ibwt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ibwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/ibwt_front.sv =====
// Front end: accepts requests and holds them in a two-entry queue.
// Depends on ibwt_pkg.
module ibwt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            req_type_i,
  input  logic [7:0]      data_byte_i,
  input  logic            is_last_i,
  input  logic [15:0]     origin_index_i,
  output logic            q_valid_o,
  input  logic            q_pop_i,
  output ibwt_pkg::item_t q_item_o
);

  ibwt_pkg::item_t slot_q [2];
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q;
  logic            push;
  ibwt_pkg::item_t new_item;

  // Classify the incoming request.
  always_comb begin
    new_item.req    = req_type_i ? ibwt_pkg::REQ_DRAIN : ibwt_pkg::REQ_LOAD;
    new_item.data   = data_byte_i;
    new_item.last   = is_last_i;
    new_item.origin = origin_index_i;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = slot_q[rptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= new_item;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (q_pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

// ===== hdl/ibwt_back.sv =====
// Back end: loads the block, forms prefix sums, walks the rank chain and drains.
// Depends on ibwt_pkg and ibwt_ram.
module ibwt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  ibwt_pkg::item_t q_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o,
  output logic [1:0]      status_o
);

  localparam int AW = ibwt_pkg::AddrW;
  localparam int LW = ibwt_pkg::LenW;
  localparam int CW = ibwt_pkg::CntW;

  ibwt_pkg::back_state_e state_q, state_d;
  ibwt_pkg::item_t       item_q;
  ibwt_pkg::status_e     res_q;

  logic [LW-1:0] len_q, pos_q, wk_q;
  logic [AW-1:0] row_q;
  logic [7:0]    k_q;
  logic [CW-1:0] acc_q;
  logic          ovf_q, rdy_q;
  logic [ibwt_pkg::SymN-1:0] vld_q;

  logic          ov_q, ol_q;
  logic [7:0]    ob_q;
  logic [1:0]    os_q;
  logic          can_emit;
  logic          emit;

  // RAM ports.
  logic          cnt_we;
  logic [7:0]    cnt_waddr, cnt_raddr;
  logic [CW-1:0] cnt_wdata, cnt_rdata, cnt_val;
  logic          lc_we, out_we;
  logic [7:0]    lc_rdata, out_rdata;
  logic [AW-1:0] rank_rdata, out_waddr;
  logic [LW-1:0] len_inc;
  logic          has_room;

  ibwt_ram #(.WIDTH(CW), .DEPTH(ibwt_pkg::SymN)) u_cnt (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(cnt_raddr), .rdata_o(cnt_rdata)
  );
  ibwt_ram #(.WIDTH(8), .DEPTH(ibwt_pkg::BlockMax)) u_lc (
    .clk_i, .we_i(lc_we), .waddr_i(len_q[AW-1:0]), .wdata_i(item_q.data),
    .raddr_i(row_q), .rdata_o(lc_rdata)
  );
  ibwt_ram #(.WIDTH(AW), .DEPTH(ibwt_pkg::BlockMax)) u_rank (
    .clk_i, .we_i(lc_we), .waddr_i(len_q[AW-1:0]), .wdata_i(cnt_val[AW-1:0]),
    .raddr_i(row_q), .rdata_o(rank_rdata)
  );
  ibwt_ram #(.WIDTH(8), .DEPTH(ibwt_pkg::BlockMax)) u_out (
    .clk_i, .we_i(out_we), .waddr_i(out_waddr), .wdata_i(lc_rdata),
    .raddr_i(pos_q[AW-1:0]), .rdata_o(out_rdata)
  );

  assign can_emit  = !ov_q || out_ready_i;
  assign emit      = can_emit && (state_q == ibwt_pkg::BK_RES ||
                                  state_q == ibwt_pkg::BK_DRN_OUT);
  assign has_room  = (len_q < LW'(ibwt_pkg::BlockMax));
  assign len_inc   = len_q + LW'(1);
  assign out_waddr = AW'(wk_q - LW'(1));

  // While loading and forming prefix sums, a count entry whose valid bit is clear reads as zero.
  always_comb begin
    cnt_val = '0;
    unique case (state_q)
      ibwt_pkg::BK_LD_WR:  cnt_val = vld_q[item_q.data] ? cnt_rdata : '0;
      ibwt_pkg::BK_PFX_WR: cnt_val = vld_q[k_q] ? cnt_rdata : '0;
      default:             cnt_val = cnt_rdata;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ibwt_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.req == ibwt_pkg::REQ_LOAD) begin
            state_d = ibwt_pkg::BK_LD_WR;
          end else if (rdy_q && pos_q < len_q) begin
            state_d = ibwt_pkg::BK_DRN_OUT;
          end else begin
            state_d = ibwt_pkg::BK_RES;
          end
        end
      end
      ibwt_pkg::BK_LD_WR: begin
        if (!item_q.last) begin
          state_d = ibwt_pkg::BK_IDLE;
        end else if (ovf_q || !has_room ||
                     32'(item_q.origin) >= 32'(len_inc)) begin
          state_d = ibwt_pkg::BK_RES;
        end else begin
          state_d = ibwt_pkg::BK_PFX_RD;
        end
      end
      ibwt_pkg::BK_PFX_RD: state_d = ibwt_pkg::BK_PFX_WR;
      ibwt_pkg::BK_PFX_WR: if (k_q == 8'd255) state_d = ibwt_pkg::BK_WK_RD;
      ibwt_pkg::BK_WK_RD:  state_d = ibwt_pkg::BK_WK_CNT;
      ibwt_pkg::BK_WK_CNT: state_d = ibwt_pkg::BK_WK_NXT;
      ibwt_pkg::BK_WK_NXT: begin
        state_d = (wk_q == LW'(1)) ? ibwt_pkg::BK_RES : ibwt_pkg::BK_WK_RD;
      end
      ibwt_pkg::BK_RES:     if (can_emit) state_d = ibwt_pkg::BK_IDLE;
      ibwt_pkg::BK_DRN_OUT: if (can_emit) state_d = ibwt_pkg::BK_IDLE;
      default:              state_d = ibwt_pkg::BK_IDLE;
    endcase
  end

  // Memory controls and queue pop.
  always_comb begin
    q_pop_o   = 1'b0;
    cnt_we    = 1'b0;
    cnt_waddr = item_q.data;
    cnt_wdata = cnt_val + CW'(1);
    cnt_raddr = q_item_i.data;
    lc_we     = 1'b0;
    out_we    = 1'b0;
    unique case (state_q)
      ibwt_pkg::BK_IDLE: q_pop_o = q_valid_i;
      ibwt_pkg::BK_LD_WR: begin
        cnt_we = has_room;
        lc_we  = has_room;
      end
      ibwt_pkg::BK_PFX_RD: cnt_raddr = 8'd0;
      ibwt_pkg::BK_PFX_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = k_q;
        cnt_wdata = acc_q;
        cnt_raddr = k_q + 8'd1;
      end
      ibwt_pkg::BK_WK_CNT: begin
        out_we    = 1'b1;
        cnt_raddr = lc_rdata;
      end
      default: cnt_raddr = q_item_i.data;
    endcase
  end

  // Item hold register.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) item_q <= q_item_i;
  end

  // Block state and sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ibwt_pkg::BK_IDLE;
      len_q   <= '0;
      pos_q   <= '0;
      wk_q    <= '0;
      row_q   <= '0;
      k_q     <= '0;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      rdy_q   <= 1'b0;
      vld_q   <= '0;
      res_q   <= ibwt_pkg::ST_EMPTY;
      ov_q    <= 1'b0;
      ob_q    <= '0;
      ol_q    <= 1'b0;
      os_q    <= '0;
    end else begin
      state_q <= state_d;
      // The output register fills on a result and empties when taken.
      if (emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      unique case (state_q)
        ibwt_pkg::BK_IDLE: begin
          res_q <= ibwt_pkg::ST_EMPTY;
          // A load abandons any output still pending.
          if (q_valid_i && q_item_i.req == ibwt_pkg::REQ_LOAD && rdy_q) begin
            rdy_q <= 1'b0;
            len_q <= '0;
            pos_q <= '0;
            vld_q <= '0;
            ovf_q <= 1'b0;
          end
        end
        ibwt_pkg::BK_LD_WR: begin
          row_q <= AW'(32'(item_q.origin));
          k_q   <= '0;
          acc_q <= '0;
          wk_q  <= has_room ? len_inc : len_q;
          if (item_q.last && state_d == ibwt_pkg::BK_RES) begin
            res_q <= ibwt_pkg::ST_REJECT;
            len_q <= '0;
            pos_q <= '0;
            rdy_q <= 1'b0;
            vld_q <= '0;
            ovf_q <= 1'b0;
          end else if (has_room) begin
            vld_q[item_q.data] <= 1'b1;
            len_q <= len_inc;
          end else begin
            ovf_q <= 1'b1;
          end
        end
        ibwt_pkg::BK_PFX_WR: begin
          vld_q[k_q] <= 1'b1;
          acc_q      <= acc_q + cnt_val;
          k_q        <= k_q + 8'd1;
        end
        ibwt_pkg::BK_WK_NXT: begin
          row_q <= AW'(CW'(rank_rdata) + cnt_rdata);
          wk_q  <= wk_q - LW'(1);
          if (wk_q == LW'(1)) begin
            res_q <= ibwt_pkg::ST_ACCEPT;
            vld_q <= '0;
            ovf_q <= 1'b0;
            pos_q <= '0;
            rdy_q <= 1'b1;
          end
        end
        ibwt_pkg::BK_RES: begin
          if (can_emit) begin
            ob_q <= '0;
            ol_q <= 1'b0;
            os_q <= res_q;
          end
        end
        ibwt_pkg::BK_DRN_OUT: begin
          if (can_emit) begin
            ob_q <= out_rdata;
            os_q <= ibwt_pkg::ST_DATA;
            ol_q <= (pos_q + LW'(1) == len_q);
            if (pos_q + LW'(1) == len_q) begin
              rdy_q <= 1'b0;
              len_q <= '0;
              pos_q <= '0;
            end else begin
              pos_q <= pos_q + LW'(1);
            end
          end
        end
        default: res_q <= res_q;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign out_last_o  = ol_q;
  assign status_o    = os_q;

  // Checks on the block state.
  a_rdy_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdy_q |-> (len_q != '0 && pos_q < len_q))
    else $error("output ready with nothing to drain");
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> len_q == LW'(ibwt_pkg::BlockMax))
    else $error("overflow flagged below capacity");
  a_walk_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ibwt_pkg::BK_WK_RD) |-> (wk_q != '0 && wk_q <= len_q))
    else $error("walk counter out of range");
  a_last_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ol_q) |-> os_q == ibwt_pkg::ST_DATA)
    else $error("last flag on a status result");

endmodule

// ===== hdl/inverse_bwt_block_unit.sv =====
// Top level of the inverse BWT block: front queue and back engine.
// Depends on ibwt_pkg, ibwt_front and ibwt_back.
//
// Usage: requests arrive on a valid/ready channel. A load request carries one
// last-column byte; the request flagged last also carries the origin row and
// yields one result, status accepted or rejected. Drain requests each yield
// one result: the next recovered byte (out_last on the final one) or status
// nothing-to-drain.
// Sequencing: a load passes through the idle and write states of the engine.
// The final load then forms prefix sums over the 256 symbol counts and walks
// the rank chain through its read, count and next states for each byte,
// following the chained reads of the last-column, rank and count memories.
// A drain passes through the idle state and the registered output memory read.
// A two-entry request queue sits ahead of the engine, and results wait in an
// output register, so the sender may keep pushing while the receiver stalls
// until the queue fills; the engine holds when the output register is full.
// Reset clears all control state and the count valid bits at once; the
// large stores need no clearing.
module inverse_bwt_block_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic        is_last_i,
  input  logic [15:0] origin_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic [1:0]  status_o
);

  logic            q_valid, q_pop;
  ibwt_pkg::item_t q_item;

  // Request queue.
  ibwt_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .data_byte_i,
    .is_last_i, .origin_index_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  // Transform engine.
  ibwt_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .out_valid_o, .out_ready_i, .out_byte_o, .out_last_o, .status_o
  );

endmodule
